// ===== rtl/core/ubac_pkg.sv =====
// Shared types, constants and helpers of the undefined-blend alpha compositor.
package ubac_pkg;

    // Fixed-point format: FRAC_BITS fraction bits, ONE means 1.0.
    localparam int FRAC_BITS = 12;
    localparam int CHAN_W    = 13;
    localparam logic [CHAN_W-1:0] ONE = CHAN_W'(1 << FRAC_BITS);

    // Product, dividend and divisor widths of the datapath.
    localparam int PROD_W     = 2 * CHAN_W;
    localparam int NUM_W      = 2 * FRAC_BITS + 13;
    localparam int DEN_W      = 2 * FRAC_BITS + 1;
    localparam int DIV_STAGES = CHAN_W;

    // Configuration port.
    localparam int DATA_W = 32;
    localparam int ADDR_W = 5;

    typedef logic [CHAN_W-1:0] t_chan;
    typedef t_chan [3:0]       t_rgba;
    typedef logic [PROD_W-1:0] t_prod;
    typedef logic [NUM_W-1:0]  t_num;
    typedef logic [DEN_W-1:0]  t_den;
    typedef t_num [2:0]        t_num3;
    typedef t_chan [2:0]       t_quot3;

    // Channel positions inside a color word.
    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;
    localparam int CH_ALPHA = 3;

    // Which rule pulls the layer toward the undefined color.
    typedef enum logic [2:0] {
        BC_UNDEF,
        BC_KEEP,
        BC_FADE,
        BC_LERP,
        BC_MIX,
        BC_FILL
    } t_bcase;

    // Register indexes of the configuration port.
    typedef enum logic [2:0] {
        REG_OPACITY,
        REG_UNDEF_RED,
        REG_UNDEF_GREEN,
        REG_UNDEF_BLUE,
        REG_UNDEF_ALPHA
    } t_reg_idx;

    // Saturated configuration as the pipeline sees it.
    typedef struct packed {
        t_rgba undef_col;
        t_chan opacity;
    } t_cfg;

    // Context that rides along with the blend division.
    typedef struct packed {
        t_rgba  c;
        t_rgba  d;
        logic   first;
        t_bcase bcase;
        t_rgba  lerp;
        t_chan  mix_a;
        t_chan  fade_a;
        t_chan  fill_a;
    } t_blend_ctx;

    // Context that rides along with the compositing division.
    typedef struct packed {
        t_rgba c;
        t_rgba d;
        logic  first;
        logic  den_zero;
        t_chan comp_a;
    } t_comp_ctx;

    localparam int SIDE_W = ($bits(t_blend_ctx) > $bits(t_comp_ctx)) ?
                            $bits(t_blend_ctx) : $bits(t_comp_ctx);
    typedef logic [SIDE_W-1:0] t_side;

    // Clamp a channel to 1.0.
    function automatic t_chan sat_chan(input t_chan v);
        return (v > ONE) ? ONE : v;
    endfunction

endpackage

// ===== rtl/core/ubac_div_pipe.sv =====
// Pipelined three-lane restoring divider with a shared divisor, one quotient bit per stage.
module ubac_div_pipe (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  ubac_pkg::t_num3  i_num,
    input  ubac_pkg::t_den   i_den,
    input  ubac_pkg::t_side  i_side,
    output logic             o_valid,
    output ubac_pkg::t_quot3 o_quot,
    output ubac_pkg::t_side  o_side
);

    logic [ubac_pkg::DIV_STAGES-1:0] r_v;
    ubac_pkg::t_num3  r_rem  [ubac_pkg::DIV_STAGES];
    ubac_pkg::t_quot3 r_q    [ubac_pkg::DIV_STAGES];
    ubac_pkg::t_den   r_den  [ubac_pkg::DIV_STAGES];
    ubac_pkg::t_side  r_side [ubac_pkg::DIV_STAGES];

    for (genvar s = 0; s < ubac_pkg::DIV_STAGES; s++) begin : g_stage
        localparam int BIT = ubac_pkg::DIV_STAGES - 1 - s;

        logic             p_v;
        ubac_pkg::t_num3  p_rem;
        ubac_pkg::t_quot3 p_q;
        ubac_pkg::t_den   p_den;
        ubac_pkg::t_side  p_side;
        ubac_pkg::t_num   sh;
        ubac_pkg::t_num3  n_rem;
        ubac_pkg::t_quot3 n_q;

        // The first stage takes the operands, later stages the previous partial results.
        if (s == 0) begin : g_head
            assign p_v    = i_valid;
            assign p_rem  = i_num;
            assign p_q    = '0;
            assign p_den  = i_den;
            assign p_side = i_side;
        end else begin : g_body
            assign p_v    = r_v[s-1];
            assign p_rem  = r_rem[s-1];
            assign p_q    = r_q[s-1];
            assign p_den  = r_den[s-1];
            assign p_side = r_side[s-1];
        end

        // Trial subtraction of the divisor aligned to this quotient bit.
        assign sh = ubac_pkg::t_num'(p_den) << BIT;

        always_comb begin
            for (int l = 0; l < 3; l++) begin
                n_rem[l] = p_rem[l];
                n_q[l]   = p_q[l];
                if (p_rem[l] >= sh) begin
                    n_rem[l]    = p_rem[l] - sh;
                    n_q[l][BIT] = 1'b1;
                end
            end
        end

        // Valid bit of this stage.
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (i_en) begin
                r_v[s] <= p_v;
            end
        end

        // Payload of this stage.
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= n_rem;
                r_q[s]    <= n_q;
                r_den[s]  <= p_den;
                r_side[s] <= p_side;
            end
        end
    end

    assign o_valid = r_v[ubac_pkg::DIV_STAGES-1];
    assign o_quot  = r_q[ubac_pkg::DIV_STAGES-1];
    assign o_side  = r_side[ubac_pkg::DIV_STAGES-1];

endmodule

// ===== rtl/core/ubac_blend.sv =====
// Pipeline that pulls the layer color toward the undefined color by the weight.
module ubac_blend (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic            i_first,
    input  ubac_pkg::t_rgba i_layer,
    input  ubac_pkg::t_chan i_weight,
    input  ubac_pkg::t_rgba i_dest,
    input  ubac_pkg::t_cfg  i_cfg,
    output logic            o_valid,
    output logic            o_first,
    output ubac_pkg::t_rgba o_col,
    output ubac_pkg::t_rgba o_dest
);

    localparam int A = ubac_pkg::CH_ALPHA;
    localparam int FB = ubac_pkg::FRAC_BITS;

    ubac_pkg::t_rgba U;
    assign U = i_cfg.undef_col;

    // Stage 1: saturate the fields and classify the blend.
    ubac_pkg::t_rgba  n1_c, n1_d;
    ubac_pkg::t_chan  n1_u;
    ubac_pkg::t_bcase n1_case;
    logic             r1_v, r1_first;
    ubac_pkg::t_rgba  r1_c, r1_d;
    ubac_pkg::t_chan  r1_u, r1_om;
    ubac_pkg::t_bcase r1_case;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            n1_c[k] = ubac_pkg::sat_chan(i_layer[k]);
            n1_d[k] = ubac_pkg::sat_chan(i_dest[k]);
        end
        n1_u = ubac_pkg::sat_chan(i_weight);
        if (n1_u >= ubac_pkg::ONE) begin
            n1_case = ubac_pkg::BC_UNDEF;
        end else if (n1_u == '0) begin
            n1_case = ubac_pkg::BC_KEEP;
        end else if (U[A] == '0) begin
            n1_case = ubac_pkg::BC_FADE;
        end else if (U[A] >= ubac_pkg::ONE && n1_c[A] >= ubac_pkg::ONE) begin
            n1_case = ubac_pkg::BC_LERP;
        end else if (n1_c[A] != '0) begin
            n1_case = ubac_pkg::BC_MIX;
        end else begin
            n1_case = ubac_pkg::BC_FILL;
        end
    end

    // Stage 2: layer and undefined color scaled by their weights.
    ubac_pkg::t_prod [3:0] n2_pc, n2_pu;
    logic                  r2_v, r2_first;
    ubac_pkg::t_rgba       r2_c, r2_d;
    ubac_pkg::t_bcase      r2_case;
    ubac_pkg::t_prod [3:0] r2_pc, r2_pu;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            n2_pc[k] = ubac_pkg::t_prod'(r1_c[k]) * ubac_pkg::t_prod'(r1_om);
            n2_pu[k] = ubac_pkg::t_prod'(U[k]) * ubac_pkg::t_prod'(r1_u);
        end
    end

    // Stage 3: plain lerp, alpha-weighted numerator terms and the divisor.
    logic [ubac_pkg::PROD_W:0]                  s3_sum [4];
    logic [ubac_pkg::CHAN_W+ubac_pkg::PROD_W-1:0] s3_mc [3];
    logic [ubac_pkg::CHAN_W+ubac_pkg::PROD_W-1:0] s3_mu [3];
    ubac_pkg::t_rgba  n3_lerp;
    logic             r3_v, r3_first;
    ubac_pkg::t_rgba  r3_c, r3_d, r3_lerp;
    ubac_pkg::t_bcase r3_case;
    ubac_pkg::t_num3  r3_mc, r3_mu;
    ubac_pkg::t_den   r3_den;
    ubac_pkg::t_chan  r3_fade_a, r3_fill_a;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            s3_sum[k]  = {1'b0, r2_pc[k]} + {1'b0, r2_pu[k]};
            n3_lerp[k] = ubac_pkg::t_chan'(s3_sum[k] >> FB);
        end
        for (int l = 0; l < 3; l++) begin
            s3_mc[l] = (ubac_pkg::CHAN_W+ubac_pkg::PROD_W)'(r2_c[l]) *
                       (ubac_pkg::CHAN_W+ubac_pkg::PROD_W)'(r2_pc[A]);
            s3_mu[l] = (ubac_pkg::CHAN_W+ubac_pkg::PROD_W)'(U[l]) *
                       (ubac_pkg::CHAN_W+ubac_pkg::PROD_W)'(r2_pu[A]);
        end
    end

    // Stage 4: dividend of the alpha-weighted mix and the context word.
    ubac_pkg::t_blend_ctx n4_ctx;
    logic                 r4_v;
    ubac_pkg::t_num3      r4_num;
    ubac_pkg::t_den       r4_den;
    ubac_pkg::t_side      r4_side;

    always_comb begin
        n4_ctx.c      = r3_c;
        n4_ctx.d      = r3_d;
        n4_ctx.first  = r3_first;
        n4_ctx.bcase  = r3_case;
        n4_ctx.lerp   = r3_lerp;
        n4_ctx.mix_a  = ubac_pkg::sat_chan(ubac_pkg::t_chan'(r3_den >> FB));
        n4_ctx.fade_a = r3_fade_a;
        n4_ctx.fill_a = r3_fill_a;
    end

    // Valid bits of stages 1 to 4.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
        end
    end

    // Payload of stages 1 to 4.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_first  <= i_first;
            r1_c      <= n1_c;
            r1_d      <= n1_d;
            r1_u      <= n1_u;
            r1_om     <= ubac_pkg::ONE - n1_u;
            r1_case   <= n1_case;
            r2_first  <= r1_first;
            r2_c      <= r1_c;
            r2_d      <= r1_d;
            r2_case   <= r1_case;
            r2_pc     <= n2_pc;
            r2_pu     <= n2_pu;
            r3_first  <= r2_first;
            r3_c      <= r2_c;
            r3_d      <= r2_d;
            r3_case   <= r2_case;
            r3_lerp   <= n3_lerp;
            for (int l = 0; l < 3; l++) begin
                r3_mc[l] <= ubac_pkg::t_num'(s3_mc[l]);
                r3_mu[l] <= ubac_pkg::t_num'(s3_mu[l]);
            end
            r3_den    <= ubac_pkg::t_den'(r2_pc[A]) + ubac_pkg::t_den'(r2_pu[A]);
            r3_fade_a <= ubac_pkg::t_chan'(r2_pc[A] >> FB);
            r3_fill_a <= ubac_pkg::t_chan'(r2_pu[A] >> FB);
            for (int l = 0; l < 3; l++) begin
                r4_num[l] <= r3_mc[l] + r3_mu[l];
            end
            r4_den    <= r3_den;
            r4_side   <= ubac_pkg::t_side'(n4_ctx);
        end
    end

    // Division of the alpha-weighted mix.
    logic                 dv_valid;
    ubac_pkg::t_quot3     dv_quot;
    ubac_pkg::t_side      dv_side;
    ubac_pkg::t_blend_ctx dv_ctx;

    ubac_div_pipe u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r4_v),
        .i_num   (r4_num),
        .i_den   (r4_den),
        .i_side  (r4_side),
        .o_valid (dv_valid),
        .o_quot  (dv_quot),
        .o_side  (dv_side)
    );

    assign dv_ctx = ubac_pkg::t_blend_ctx'(dv_side[$bits(ubac_pkg::t_blend_ctx)-1:0]);

    // Stage 5: pick the blended color by the rule chosen in stage 1.
    ubac_pkg::t_rgba n5_col;
    logic            r5_v, r5_first;
    ubac_pkg::t_rgba r5_col, r5_d;

    always_comb begin
        case (dv_ctx.bcase)
            ubac_pkg::BC_UNDEF: n5_col = U;
            ubac_pkg::BC_FADE: begin
                n5_col    = dv_ctx.c;
                n5_col[A] = dv_ctx.fade_a;
            end
            ubac_pkg::BC_LERP: n5_col = dv_ctx.lerp;
            ubac_pkg::BC_MIX: begin
                for (int l = 0; l < 3; l++) begin
                    n5_col[l] = ubac_pkg::sat_chan(dv_quot[l]);
                end
                n5_col[A] = dv_ctx.mix_a;
            end
            ubac_pkg::BC_FILL: begin
                n5_col    = U;
                n5_col[A] = dv_ctx.fill_a;
            end
            default: n5_col = dv_ctx.c;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else if (i_en) begin
            r5_v <= dv_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_first <= dv_ctx.first;
            r5_col   <= n5_col;
            r5_d     <= dv_ctx.d;
        end
    end

    assign o_valid = r5_v;
    assign o_first = r5_first;
    assign o_col   = r5_col;
    assign o_dest  = r5_d;

endmodule

// ===== rtl/core/ubac_comp.sv =====
// Pipeline that applies opacity and composites the layer behind the destination.
module ubac_comp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic            i_first,
    input  ubac_pkg::t_rgba i_col,
    input  ubac_pkg::t_rgba i_dest,
    input  ubac_pkg::t_chan i_opacity,
    output logic            o_valid,
    output ubac_pkg::t_rgba o_pix
);

    localparam int A = ubac_pkg::CH_ALPHA;
    localparam int FB = ubac_pkg::FRAC_BITS;
    localparam int WM = ubac_pkg::CHAN_W + ubac_pkg::PROD_W;

    // Stage 6: scale alpha by opacity.
    ubac_pkg::t_prod n6_pa;
    ubac_pkg::t_rgba n6_c;
    logic            r6_v, r6_first;
    ubac_pkg::t_rgba r6_c, r6_d;

    always_comb begin
        n6_pa = ubac_pkg::t_prod'(i_col[A]) * ubac_pkg::t_prod'(i_opacity);
        n6_c  = i_col;
        if (i_opacity < ubac_pkg::ONE) begin
            n6_c[A] = ubac_pkg::t_chan'(n6_pa >> FB);
        end
    end

    // Stage 7: layer weight behind the destination and destination color terms.
    ubac_pkg::t_prod       n7_b;
    ubac_pkg::t_prod [2:0] n7_dd;
    logic                  r7_v, r7_first;
    ubac_pkg::t_rgba       r7_c, r7_d;
    ubac_pkg::t_prod       r7_b;
    ubac_pkg::t_prod [2:0] r7_dd;

    always_comb begin
        n7_b = ubac_pkg::t_prod'(r6_c[A]) * ubac_pkg::t_prod'(ubac_pkg::ONE - r6_d[A]);
        for (int l = 0; l < 3; l++) begin
            n7_dd[l] = ubac_pkg::t_prod'(r6_d[l]) * ubac_pkg::t_prod'(r6_d[A]);
        end
    end

    // Stage 8: layer color terms, destination terms aligned, and the divisor.
    logic [WM-1:0]   s8_mc [3];
    logic            r8_v, r8_first;
    ubac_pkg::t_rgba r8_c, r8_d;
    ubac_pkg::t_num3 r8_mc, r8_md;
    ubac_pkg::t_den  r8_den;

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            s8_mc[l] = WM'(r7_c[l]) * WM'(r7_b);
        end
    end

    // Stage 9: dividend and the context word.
    ubac_pkg::t_comp_ctx n9_ctx;
    logic                r9_v;
    ubac_pkg::t_num3     r9_num;
    ubac_pkg::t_den      r9_den;
    ubac_pkg::t_side     r9_side;

    always_comb begin
        n9_ctx.c        = r8_c;
        n9_ctx.d        = r8_d;
        n9_ctx.first    = r8_first;
        n9_ctx.den_zero = (r8_den == '0);
        n9_ctx.comp_a   = ubac_pkg::sat_chan(ubac_pkg::t_chan'(r8_den >> FB));
    end

    // Valid bits of stages 6 to 9.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
            r7_v <= 1'b0;
            r8_v <= 1'b0;
            r9_v <= 1'b0;
        end else if (i_en) begin
            r6_v <= i_valid;
            r7_v <= r6_v;
            r8_v <= r7_v;
            r9_v <= r8_v;
        end
    end

    // Payload of stages 6 to 9.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r6_first <= i_first;
            r6_c     <= n6_c;
            r6_d     <= i_dest;
            r7_first <= r6_first;
            r7_c     <= r6_c;
            r7_d     <= r6_d;
            r7_b     <= n7_b;
            r7_dd    <= n7_dd;
            r8_first <= r7_first;
            r8_c     <= r7_c;
            r8_d     <= r7_d;
            for (int l = 0; l < 3; l++) begin
                r8_mc[l] <= ubac_pkg::t_num'(s8_mc[l]);
                r8_md[l] <= ubac_pkg::t_num'(r7_dd[l]) << FB;
            end
            r8_den   <= (ubac_pkg::t_den'(r7_d[A]) << FB) + ubac_pkg::t_den'(r7_b);
            for (int l = 0; l < 3; l++) begin
                r9_num[l] <= r8_mc[l] + r8_md[l];
            end
            r9_den   <= r8_den;
            r9_side  <= ubac_pkg::t_side'(n9_ctx);
        end
    end

    // Division that renormalizes the composited color.
    logic                dv_valid;
    ubac_pkg::t_quot3    dv_quot;
    ubac_pkg::t_side     dv_side;
    ubac_pkg::t_comp_ctx dv_ctx;

    ubac_div_pipe u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r9_v),
        .i_num   (r9_num),
        .i_den   (r9_den),
        .i_side  (r9_side),
        .o_valid (dv_valid),
        .o_quot  (dv_quot),
        .o_side  (dv_side)
    );

    assign dv_ctx = ubac_pkg::t_comp_ctx'(dv_side[$bits(ubac_pkg::t_comp_ctx)-1:0]);

    // Stage 10: first layer passes through, an empty sum keeps the destination.
    ubac_pkg::t_rgba n10_pix;
    logic            r10_v;
    ubac_pkg::t_rgba r10_pix;

    always_comb begin
        if (dv_ctx.first) begin
            n10_pix = dv_ctx.c;
        end else begin
            for (int l = 0; l < 3; l++) begin
                n10_pix[l] = dv_ctx.den_zero ? dv_ctx.d[l] : ubac_pkg::sat_chan(dv_quot[l]);
            end
            n10_pix[A] = dv_ctx.comp_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r10_v <= 1'b0;
        end else if (i_en) begin
            r10_v <= dv_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r10_pix <= n10_pix;
        end
    end

    assign o_valid = r10_v;
    assign o_pix   = r10_pix;

endmodule

// ===== rtl/core/undef_blend_alpha_composite_top.sv =====
// Undefined-color blend and front-to-back alpha compositor, one pixel per word.
//
// The block takes one pixel word per clock and returns one composited word per
// clock while the output is not stalled. The datapath is built from two fully
// pipelined restoring dividers, one quotient bit per stage (13 stages each), one
// for the alpha-weighted undefined mix and one for the over renormalization,
// plus the multiply stages around them. While the output word is stalled the
// whole pipeline holds and the input is stalled. Configuration registers are
// read by the pipeline as it runs and are to be written only while it is empty.
module undef_blend_alpha_composite_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Configuration port.
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ubac_pkg::ADDR_W-1:0]   paddr,
    input  logic [ubac_pkg::DATA_W-1:0]   pwdata,
    output logic [ubac_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    // Input words.
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_first_layer,
    input  logic [ubac_pkg::CHAN_W-1:0]   i_layer_red,
    input  logic [ubac_pkg::CHAN_W-1:0]   i_layer_green,
    input  logic [ubac_pkg::CHAN_W-1:0]   i_layer_blue,
    input  logic [ubac_pkg::CHAN_W-1:0]   i_layer_alpha,
    input  logic [ubac_pkg::CHAN_W-1:0]   i_undef_weight,
    input  logic [ubac_pkg::CHAN_W-1:0]   i_dest_red,
    input  logic [ubac_pkg::CHAN_W-1:0]   i_dest_green,
    input  logic [ubac_pkg::CHAN_W-1:0]   i_dest_blue,
    input  logic [ubac_pkg::CHAN_W-1:0]   i_dest_alpha,
    // Output words.
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [ubac_pkg::CHAN_W-1:0]   o_out_red,
    output logic [ubac_pkg::CHAN_W-1:0]   o_out_green,
    output logic [ubac_pkg::CHAN_W-1:0]   o_out_blue,
    output logic [ubac_pkg::CHAN_W-1:0]   o_out_alpha
);

    // Configuration registers.
    ubac_pkg::t_chan    r_opacity, r_undef_red, r_undef_green, r_undef_blue, r_undef_alpha;
    ubac_pkg::t_reg_idx reg_idx;
    logic               cfg_wr;

    assign reg_idx = ubac_pkg::t_reg_idx'(paddr[ubac_pkg::ADDR_W-1:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_opacity     <= ubac_pkg::ONE;
            r_undef_red   <= ubac_pkg::ONE;
            r_undef_green <= ubac_pkg::ONE;
            r_undef_blue  <= ubac_pkg::ONE;
            r_undef_alpha <= ubac_pkg::ONE;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                ubac_pkg::REG_OPACITY:     r_opacity     <= pwdata[ubac_pkg::CHAN_W-1:0];
                ubac_pkg::REG_UNDEF_RED:   r_undef_red   <= pwdata[ubac_pkg::CHAN_W-1:0];
                ubac_pkg::REG_UNDEF_GREEN: r_undef_green <= pwdata[ubac_pkg::CHAN_W-1:0];
                ubac_pkg::REG_UNDEF_BLUE:  r_undef_blue  <= pwdata[ubac_pkg::CHAN_W-1:0];
                ubac_pkg::REG_UNDEF_ALPHA: r_undef_alpha <= pwdata[ubac_pkg::CHAN_W-1:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        unique case (reg_idx)
            ubac_pkg::REG_OPACITY:     prdata = ubac_pkg::DATA_W'(r_opacity);
            ubac_pkg::REG_UNDEF_RED:   prdata = ubac_pkg::DATA_W'(r_undef_red);
            ubac_pkg::REG_UNDEF_GREEN: prdata = ubac_pkg::DATA_W'(r_undef_green);
            ubac_pkg::REG_UNDEF_BLUE:  prdata = ubac_pkg::DATA_W'(r_undef_blue);
            ubac_pkg::REG_UNDEF_ALPHA: prdata = ubac_pkg::DATA_W'(r_undef_alpha);
            default:                   prdata = '0;
        endcase
    end

    // Saturated configuration for the pipeline.
    ubac_pkg::t_cfg cfg;

    always_comb begin
        cfg.opacity                        = ubac_pkg::sat_chan(r_opacity);
        cfg.undef_col[ubac_pkg::CH_RED]    = ubac_pkg::sat_chan(r_undef_red);
        cfg.undef_col[ubac_pkg::CH_GREEN]  = ubac_pkg::sat_chan(r_undef_green);
        cfg.undef_col[ubac_pkg::CH_BLUE]   = ubac_pkg::sat_chan(r_undef_blue);
        cfg.undef_col[ubac_pkg::CH_ALPHA]  = ubac_pkg::sat_chan(r_undef_alpha);
    end

    // The pipeline advances unless a finished word is held at the output.
    logic en;
    assign o_in_stall = o_out_valid && i_out_stall;
    assign en         = !o_in_stall;

    // Input words packed into color vectors.
    ubac_pkg::t_rgba layer, dest;

    always_comb begin
        layer[ubac_pkg::CH_RED]   = i_layer_red;
        layer[ubac_pkg::CH_GREEN] = i_layer_green;
        layer[ubac_pkg::CH_BLUE]  = i_layer_blue;
        layer[ubac_pkg::CH_ALPHA] = i_layer_alpha;
        dest[ubac_pkg::CH_RED]    = i_dest_red;
        dest[ubac_pkg::CH_GREEN]  = i_dest_green;
        dest[ubac_pkg::CH_BLUE]   = i_dest_blue;
        dest[ubac_pkg::CH_ALPHA]  = i_dest_alpha;
    end

    logic            bl_valid, bl_first;
    ubac_pkg::t_rgba bl_col, bl_dest, pix;

    ubac_blend u_blend (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (i_in_valid),
        .i_first  (i_first_layer),
        .i_layer  (layer),
        .i_weight (i_undef_weight),
        .i_dest   (dest),
        .i_cfg    (cfg),
        .o_valid  (bl_valid),
        .o_first  (bl_first),
        .o_col    (bl_col),
        .o_dest   (bl_dest)
    );

    ubac_comp u_comp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (bl_valid),
        .i_first   (bl_first),
        .i_col     (bl_col),
        .i_dest    (bl_dest),
        .i_opacity (cfg.opacity),
        .o_valid   (o_out_valid),
        .o_pix     (pix)
    );

    assign o_out_red   = pix[ubac_pkg::CH_RED];
    assign o_out_green = pix[ubac_pkg::CH_GREEN];
    assign o_out_blue  = pix[ubac_pkg::CH_BLUE];
    assign o_out_alpha = pix[ubac_pkg::CH_ALPHA];

endmodule

// ===== rtl/core/ubac_checker.sv =====
// Port-level checks of the compositor and their attachment to the top level.
module ubac_sva (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        pready,
    input logic                        i_in_valid,
    input logic                        o_in_stall,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input logic [ubac_pkg::CHAN_W-1:0] o_out_red,
    input logic [ubac_pkg::CHAN_W-1:0] o_out_green,
    input logic [ubac_pkg::CHAN_W-1:0] o_out_blue,
    input logic [ubac_pkg::CHAN_W-1:0] o_out_alpha
);

    // A stalled output word stays valid and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_red) &&
        $stable(o_out_green) && $stable(o_out_blue) && $stable(o_out_alpha))
        else $error("stalled output word changed");

    // The input is held back only by a waiting output word.
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a held output word");

    // Results never exceed 1.0.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_red <= ubac_pkg::ONE && o_out_green <= ubac_pkg::ONE &&
        o_out_blue <= ubac_pkg::ONE && o_out_alpha <= ubac_pkg::ONE)
        else $error("output channel above 1.0");

    // Reset empties the pipeline.
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    // The configuration port never waits.
    a_pready: assert property (@(posedge i_clk) pready)
        else $error("pready low");

endmodule

bind undef_blend_alpha_composite_top ubac_sva u_ubac_checker (.*);
